// ===== src/mcss_pkg.sv =====
// ----------------------------------------------------------------------------
// mcss_pkg
// Shared types, byte codes and the duty computation of the motor command
// sequencer.
// ----------------------------------------------------------------------------
package mcss_pkg;

  // Kind of request taken from the input stream (carried in tuser).
  typedef enum logic [2:0] {
    CMD_DRIVE = 3'd0,
    CMD_CATCH = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_REPLY = 3'd4
  } cmd_e;

  // Running sequence, kept while busy.
  typedef enum logic [1:0] {
    OP_DRIVE = 2'd0,
    OP_CATCH = 2'd1,
    OP_LEFT  = 2'd2,
    OP_RIGHT = 2'd3
  } op_e;

  // Reported failure point of a sequence.
  typedef enum logic [2:0] {
    FAIL_NONE      = 3'd0,
    FAIL_HANDSHAKE = 3'd1,
    FAIL_MODE      = 3'd2,
    FAIL_CONTROL   = 3'd3,
    FAIL_LEFT      = 3'd4,
    FAIL_RIGHT     = 3'd5,
    FAIL_END       = 3'd6
  } fail_e;

  // Index of the byte last sent, whose reply is awaited.
  localparam logic [2:0] STG_HELLO   = 3'd0;
  localparam logic [2:0] STG_MODE    = 3'd1;
  localparam logic [2:0] STG_CONTROL = 3'd2;
  localparam logic [2:0] STG_LEFT    = 3'd3;
  localparam logic [2:0] STG_RIGHT   = 3'd4;
  localparam logic [2:0] STG_END     = 3'd5;

  // Bytes on the serial link.
  localparam logic [7:0] BYTE_HELLO    = 8'h48; // H
  localparam logic [7:0] BYTE_MODE     = 8'h4D; // M
  localparam logic [7:0] BYTE_END      = 8'h45; // E
  localparam logic [7:0] BYTE_CATCH    = 8'h43; // C
  localparam logic [7:0] BYTE_LEFT     = 8'h4C; // L
  localparam logic [7:0] BYTE_RIGHT    = 8'h52; // R
  localparam logic [7:0] REPLY_HELLO   = 8'h68; // h
  localparam logic [7:0] REPLY_A       = 8'h61; // a
  localparam logic [7:0] REPLY_M       = 8'h6D; // m
  localparam logic [7:0] REPLY_O       = 8'h6F; // o
  localparam logic [7:0] REPLY_K       = 8'h6B; // k
  localparam logic [3:0] NIB_FORWARD   = 4'hF;
  localparam logic [3:0] NIB_REVERSE   = 4'hB;

  // One result item.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       done_res;
    logic       success;
    logic [2:0] fail_stage;
  } result_t;

  // Duty for one wheel: min(max_pwm, (max_pwm * |power|) >> 12).
  function automatic logic [7:0] duty_of(logic [7:0] max_pwm, logic [15:0] power);
    logic [16:0] mag;
    logic [24:0] prod;
    logic [12:0] scaled;
    mag    = power[15] ? (17'h10000 - {1'b0, power}) : {1'b0, power};
    prod   = 25'(max_pwm) * 25'(mag);
    scaled = prod[24:12];
    return (scaled > 13'(max_pwm)) ? max_pwm : scaled[7:0];
  endfunction

  // Direction nibble for one wheel; zero when the duty is too small to move.
  function automatic logic [3:0] dir_nibble(logic [7:0] duty, logic negative);
    if (duty > 8'd1) begin
      return negative ? NIB_REVERSE : NIB_FORWARD;
    end
    return 4'h0;
  endfunction

endpackage

// ===== src/motor_command_spi_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// motor_command_spi_sequencer_unit
// Byte sequencer for a serial link to a two-wheel motor controller: turns
// drive, catch and prepare requests into bytes to send and checks replies.
// ----------------------------------------------------------------------------
// Each request on the slave stream is either a command (drive, catch, prepare
// left, prepare right) or a reply byte that the partner clocked back during
// the last transfer. A command accepted while idle starts a sequence and
// answers with the byte H to send; every reply then answers with the next
// byte to send, or with a done result carrying success and the failure stage.
// Commands while busy, replies while idle and unused command codes give no
// result. The block takes one request per clock while the output does not
// stall: a request is first held in an input register, and then one pass of
// logic (one 8 x 17 bit multiply and compare per wheel, the reply check and
// the state update) fills the output register, from which the master side
// takes it. Both registers advance together whenever the output register is
// empty or being taken, so the slave side stalls only while a result waits
// on the master side. max_pwm is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle, as the block itself does
// not enforce this.
module motor_command_spi_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] power_left, [31:16] power_right, [39:32] reply_byte
  input  logic [39:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte, [8] success, [11:9] fail_stage, [15:12] zero
  output logic [15:0] m_axis_tdata,
  // [0] tx_valid, [1] done_res
  output logic [1:0]  m_axis_tuser
);

  logic [7:0] max_pwm_q;

  // Input register.
  logic        in_valid_q;
  logic [2:0]  in_cmd_q;
  logic [15:0] in_pl_q;
  logic [15:0] in_pr_q;
  logic [7:0]  in_rx_q;

  // Sequence state.
  logic       busy_q, busy_d;
  logic [1:0] op_kind_q, op_kind_d;
  logic [2:0] stage_q, stage_d;
  logic [7:0] duty_left_q, duty_left_d;
  logic [7:0] duty_right_q, duty_right_d;
  logic [7:0] dir_q, dir_d;

  // Output register.
  logic                 out_valid_q;
  mcss_pkg::result_t    out_q;

  logic                 advance;
  logic                 res_valid;
  mcss_pkg::result_t    res;
  logic [7:0]           new_duty_l, new_duty_r;
  logic                 is_start;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  assign new_duty_l = mcss_pkg::duty_of(max_pwm_q, in_pl_q);
  assign new_duty_r = mcss_pkg::duty_of(max_pwm_q, in_pr_q);
  assign is_start   = (in_cmd_q == mcss_pkg::CMD_DRIVE) || (in_cmd_q == mcss_pkg::CMD_CATCH) ||
                      (in_cmd_q == mcss_pkg::CMD_LEFT)  || (in_cmd_q == mcss_pkg::CMD_RIGHT);

  always_comb begin
    logic [7:0] side_byte;
    busy_d       = busy_q;
    op_kind_d    = op_kind_q;
    stage_d      = stage_q;
    duty_left_d  = duty_left_q;
    duty_right_d = duty_right_q;
    dir_d        = dir_q;
    res_valid    = 1'b0;
    res          = '0;
    side_byte    = mcss_pkg::BYTE_RIGHT;

    if (is_start) begin
      if (!busy_q) begin
        op_kind_d = in_cmd_q[1:0];
        if (in_cmd_q == mcss_pkg::CMD_DRIVE) begin
          duty_left_d  = new_duty_l;
          duty_right_d = new_duty_r;
          dir_d        = {mcss_pkg::dir_nibble(new_duty_l, in_pl_q[15]),
                          mcss_pkg::dir_nibble(new_duty_r, in_pr_q[15])};
        end
        busy_d       = 1'b1;
        stage_d      = mcss_pkg::STG_HELLO;
        res_valid    = 1'b1;
        res.tx_valid = 1'b1;
        res.tx_byte  = mcss_pkg::BYTE_HELLO;
      end
    end else if ((in_cmd_q == mcss_pkg::CMD_REPLY) && busy_q) begin
      // Every reply yields one result: either the next byte or a finish.
      res_valid    = 1'b1;
      res.done_res = 1'b1;
      res.success  = 1'b1;
      res.fail_stage = mcss_pkg::FAIL_NONE;
      if (op_kind_q == mcss_pkg::OP_DRIVE) begin
        unique case (stage_q)
          mcss_pkg::STG_HELLO: begin
            if (in_rx_q == mcss_pkg::REPLY_HELLO) begin
              res.tx_byte = mcss_pkg::BYTE_MODE;
            end else begin
              res.fail_stage = mcss_pkg::FAIL_HANDSHAKE;
            end
          end
          mcss_pkg::STG_MODE: begin
            if (in_rx_q == mcss_pkg::REPLY_A) begin
              res.tx_byte = dir_q;
            end else begin
              res.fail_stage = mcss_pkg::FAIL_MODE;
            end
          end
          mcss_pkg::STG_CONTROL: begin
            if (in_rx_q == mcss_pkg::REPLY_M) begin
              res.tx_byte = duty_left_q;
            end else begin
              res.fail_stage = mcss_pkg::FAIL_CONTROL;
            end
          end
          mcss_pkg::STG_LEFT: begin
            if (in_rx_q == mcss_pkg::REPLY_O) begin
              res.tx_byte = duty_right_q;
            end else begin
              res.fail_stage = mcss_pkg::FAIL_LEFT;
            end
          end
          mcss_pkg::STG_RIGHT: begin
            if (in_rx_q == mcss_pkg::REPLY_K) begin
              res.tx_byte = mcss_pkg::BYTE_END;
            end else begin
              res.fail_stage = mcss_pkg::FAIL_RIGHT;
            end
          end
          mcss_pkg::STG_END: begin
            if (in_rx_q != mcss_pkg::REPLY_O) begin
              res.fail_stage = mcss_pkg::FAIL_END;
            end
          end
          default: begin
          end
        endcase
        // A send happens at every stage before the end byte when the reply matched.
        if ((stage_q != mcss_pkg::STG_END) && (stage_q <= mcss_pkg::STG_RIGHT) &&
            (res.fail_stage == mcss_pkg::FAIL_NONE)) begin
          res.tx_valid = 1'b1;
          res.done_res = 1'b0;
          res.success  = 1'b0;
        end
      end else if (stage_q == mcss_pkg::STG_HELLO) begin
        if (op_kind_q == mcss_pkg::OP_CATCH) begin
          side_byte = mcss_pkg::BYTE_CATCH;
        end else if (op_kind_q == mcss_pkg::OP_LEFT) begin
          side_byte = mcss_pkg::BYTE_LEFT;
        end
        if (in_rx_q == mcss_pkg::REPLY_HELLO) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = side_byte;
          res.done_res = 1'b0;
          res.success  = 1'b0;
        end else begin
          res.fail_stage = mcss_pkg::FAIL_HANDSHAKE;
        end
      end

      if (res.done_res) begin
        res.success = (res.fail_stage == mcss_pkg::FAIL_NONE);
        busy_d      = 1'b0;
        stage_d     = mcss_pkg::STG_HELLO;
      end else begin
        stage_d = stage_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pwm_q    <= 8'd241;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      busy_q       <= 1'b0;
      op_kind_q    <= 2'd0;
      stage_q      <= 3'd0;
      duty_left_q  <= 8'd0;
      duty_right_q <= 8'd0;
      dir_q        <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        max_pwm_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res_valid;
        if (in_valid_q) begin
          busy_q       <= busy_d;
          op_kind_q    <= op_kind_d;
          stage_q      <= stage_d;
          duty_left_q  <= duty_left_d;
          duty_right_q <= duty_right_d;
          dir_q        <= dir_d;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= s_axis_tuser;
      in_pl_q  <= s_axis_tdata[15:0];
      in_pr_q  <= s_axis_tdata[31:16];
      in_rx_q  <= s_axis_tdata[39:32];
    end
    if (advance && in_valid_q && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.fail_stage, out_q.success, out_q.tx_byte};
  assign m_axis_tuser  = {out_q.done_res, out_q.tx_valid};

  // A result either asks for a byte or ends the sequence, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result both sends a byte and finishes");

  // Success only comes with a finish and no failure stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tuser[1] && (m_axis_tdata[11:9] == 3'd0)))
    else $error("success without a clean finish");

  // Loading a finish result leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && res_valid && res.done_res) |=> !busy_q)
    else $error("sequencer still busy after finish");

  // An empty output register never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

// ===== tb/motor_command_spi_sequencer_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_command_spi_sequencer_unit_checker
// Watches both streams and the max_pwm write port of the sequencer, keeps
// its own model of the link sequence and compares every result it sees.
// ----------------------------------------------------------------------------
module motor_command_spi_sequencer_unit_checker
  import mcss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  localparam logic [7:0] MAX_PWM_RESET = 8'd241;

  // Shadow of the sequencer state and its one register.
  logic [7:0] max_pwm;
  logic       seq_busy;
  op_e        seq_op;
  logic [2:0] seq_stage;
  logic [7:0] duty_l;
  logic [7:0] duty_r;
  logic [7:0] dir_byte;

  result_t awaited_results [$];

  // Duty of one wheel from its signed Q3.12 power, saturated at max_pwm.
  function automatic logic [7:0] wheel_duty(input logic [15:0] power);
    int magnitude;
    int scaled;
    magnitude = power[15] ? 65536 - int'(power) : int'(power);
    scaled    = (int'(max_pwm) * magnitude) >>> 12;
    return (scaled > int'(max_pwm)) ? max_pwm : scaled[7:0];
  endfunction

  // Advances the shadow state by one request; returns 1 when a result follows.
  function automatic bit next_link_result(input logic [2:0] cmd, input logic [15:0] pl,
                                          input logic [15:0] pr, input logic [7:0] rx,
                                          output result_t res);
    logic [7:0] want_reply;
    logic [7:0] next_byte;
    fail_e      code;
    bit         checked;
    bit         closing;
    res        = '0;
    want_reply = '0;
    next_byte  = '0;
    code       = FAIL_NONE;
    checked    = 1'b0;
    closing    = 1'b0;
    if (cmd <= CMD_RIGHT) begin
      if (seq_busy) begin
        return 1'b0;
      end
      seq_op = op_e'(cmd[1:0]);
      if (cmd == CMD_DRIVE) begin
        duty_l   = wheel_duty(pl);
        duty_r   = wheel_duty(pr);
        dir_byte = {(duty_l > 8'd1) ? (pl[15] ? NIB_REVERSE : NIB_FORWARD) : 4'h0,
                    (duty_r > 8'd1) ? (pr[15] ? NIB_REVERSE : NIB_FORWARD) : 4'h0};
      end
      seq_busy     = 1'b1;
      seq_stage    = STG_HELLO;
      res.tx_valid = 1'b1;
      res.tx_byte  = BYTE_HELLO;
      return 1'b1;
    end
    if (cmd != CMD_REPLY || !seq_busy) begin
      return 1'b0;
    end
    if (seq_op == OP_DRIVE) begin
      checked = 1'b1;
      case (seq_stage)
        STG_HELLO: begin
          want_reply = REPLY_HELLO; next_byte = BYTE_MODE;  code = FAIL_HANDSHAKE;
        end
        STG_MODE: begin
          want_reply = REPLY_A;     next_byte = dir_byte;   code = FAIL_MODE;
        end
        STG_CONTROL: begin
          want_reply = REPLY_M;     next_byte = duty_l;     code = FAIL_CONTROL;
        end
        STG_LEFT: begin
          want_reply = REPLY_O;     next_byte = duty_r;     code = FAIL_LEFT;
        end
        STG_RIGHT: begin
          want_reply = REPLY_K;     next_byte = BYTE_END;   code = FAIL_RIGHT;
        end
        STG_END: begin
          want_reply = REPLY_O;     closing = 1'b1;         code = FAIL_END;
        end
        default: begin
          checked = 1'b0;
        end
      endcase
    end else if (seq_stage == STG_HELLO) begin
      checked    = 1'b1;
      want_reply = REPLY_HELLO;
      code       = FAIL_HANDSHAKE;
      next_byte  = (seq_op == OP_CATCH) ? BYTE_CATCH :
                   (seq_op == OP_LEFT)  ? BYTE_LEFT  : BYTE_RIGHT;
    end
    if (checked && !closing && rx == want_reply) begin
      seq_stage    = seq_stage + 3'd1;
      res.tx_valid = 1'b1;
      res.tx_byte  = next_byte;
    end else begin
      // Last reply of a sequence, an unchecked reply, or a failed check.
      seq_busy       = 1'b0;
      seq_stage      = STG_HELLO;
      res.done_res   = 1'b1;
      res.fail_stage = (checked && rx != want_reply) ? code : FAIL_NONE;
      res.success    = (res.fail_stage == FAIL_NONE);
    end
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    bit      produces;
    if (!rst_ni) begin
      max_pwm   = MAX_PWM_RESET;
      seq_busy  = 1'b0;
      seq_op    = OP_DRIVE;
      seq_stage = STG_HELLO;
      duty_l    = '0;
      duty_r    = '0;
      dir_byte  = '0;
      awaited_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // Results are checked before this edge's request is predicted.
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual tdata %h tuser %h",
                   $time, m_tdata_i, m_tuser_i);
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("tx_valid", 8'(want.tx_valid), 8'(m_tuser_i[0]));
          compare_field("done_res", 8'(want.done_res), 8'(m_tuser_i[1]));
          compare_field("tx_byte", want.tx_byte, m_tdata_i[7:0]);
          compare_field("success", 8'(want.success), 8'(m_tdata_i[8]));
          compare_field("fail_stage", 8'(want.fail_stage), 8'(m_tdata_i[11:9]));
          compare_field("tdata padding", 8'h00, 8'(m_tdata_i[15:12]));
        end
      end
      if (cfg_we_i) begin
        max_pwm = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        produces = next_link_result(s_tuser_i, s_tdata_i[15:0], s_tdata_i[31:16],
                                    s_tdata_i[39:32], want);
        if (produces) begin
          awaited_results.push_back(want);
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ===== tb/motor_command_spi_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_command_spi_sequencer_unit_tb
// Drives drive, catch and prepare sequences with partner replies into the
// sequencer across several max_pwm settings and gives the final verdict.
// ----------------------------------------------------------------------------
// The stimulus is built from whole link sequences: a command followed by the
// replies the motor controller would clock back. Most replies are the ones a
// healthy partner sends, so the sequence reaches its last stage; some carry a
// corrupted byte to end the sequence early with a failure stage. Requests the
// block must ignore (commands while busy, replies while idle, unused codes)
// are mixed in as noise. A separate checker predicts and compares every
// result; this module only makes stimulus, watches for a hang and reports.
module motor_command_spi_sequencer_unit_tb;
  import mcss_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  // Two register stages from acceptance to result, plus some margin.
  localparam int PIPE_LATENCY    = 4;
  // Cycles without any accepted request or result before the run is abandoned.
  localparam int STALL_LIMIT     = 2000;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 224;
  // Marks a sequence in which every reply is the healthy one.
  localparam int NO_FAULT        = 7;
  // Phase that runs with no idling on either side.
  localparam int BUSY_PHASE      = 5;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic [2:0]  s_tuser   = CMD_REPLY;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int driven_items = 0;
  int idle_cycles = 0;
  int mismatch_count;
  int pending;

  always #HALF_PERIOD clk_i = ~clk_i;

  motor_command_spi_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  motor_command_spi_sequencer_unit_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tuser_i        (s_tuser),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tuser_i        (m_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // The receiver stalls in about a third of the cycles unless idling is off.
  always @(posedge clk_i) begin
    m_tready <= !rx_idle_en || ($urandom_range(99) >= 33);
  end

  // Hang detection: counts cycles in which neither stream moves a request.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("motor_command_spi_sequencer_unit verification failed");
    $finish;
  end

  // Powers are spread over the whole range, the usual driving range, the
  // region where a duty of 0 or 1 leaves the direction nibble clear, and the
  // saturating extremes.
  function automatic logic [15:0] random_power();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(65535));
      1: v = int'($urandom_range(16384)) - 8192;
      2: v = int'($urandom_range(80)) - 40;
      default: begin
        case ($urandom_range(4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 4096;
          3:       v = -4096;
          default: v = 0;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  // Offers one request and returns at the edge where it is accepted. The
  // valid stays high on return so that a back-to-back request follows
  // without a gap; random idle cycles put garbage on the data lines.
  task automatic send_request(input logic [2:0] cmd, input logic [15:0] pl,
                              input logic [15:0] pr, input logic [7:0] rx);
    while (tx_idle_en && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 40'({$urandom(), $urandom()});
      s_tuser  <= 3'($urandom());
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rx, pr, pl};
    s_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_tready) begin
      @(posedge clk_i);
    end
  endtask

  // A request the block must ignore. While a sequence runs that is a new
  // command or an unused code; while idle it is a reply or an unused code.
  task automatic send_noise(input bit while_busy);
    logic [2:0] code;
    if (while_busy && $urandom_range(1) == 1) begin
      code = 3'($urandom_range(int'(CMD_RIGHT)));
    end else if (!while_busy && $urandom_range(1) == 1) begin
      code = CMD_REPLY;
    end else begin
      code = 3'(int'(CMD_REPLY) + 1 + $urandom_range(2));
    end
    send_request(code, random_power(), random_power(), 8'($urandom()));
  endtask

  // One full link sequence: the command, then the partner replies. The reply
  // with index bad_at is corrupted, which ends the sequence there.
  task automatic run_sequence(input cmd_e op, input logic [15:0] pl, input logic [15:0] pr,
                              input int bad_at, input bit noisy);
    logic [7:0] answer [6];
    logic [7:0] rx;
    int         replies;
    answer[0] = REPLY_HELLO;
    answer[1] = REPLY_A;
    answer[2] = REPLY_M;
    answer[3] = REPLY_O;
    answer[4] = REPLY_K;
    answer[5] = REPLY_O;
    replies = (op == CMD_DRIVE) ? 6 : 2;
    send_request(op, pl, pr, 8'($urandom()));
    driven_items++;
    for (int i = 0; i < replies; i++) begin
      if (noisy && $urandom_range(2) == 0) begin
        send_noise(1'b1);
      end
      // The reply to the C, L or R byte is never checked, so any byte goes.
      rx = (op != CMD_DRIVE && i == 1) ? 8'($urandom()) : answer[i];
      if (i == bad_at) begin
        rx = rx ^ 8'($urandom_range(255, 1));
      end
      send_request(CMD_REPLY, random_power(), random_power(), rx);
      driven_items++;
      if (i == bad_at) begin
        break;
      end
    end
  endtask

  // Holds the sender off until every expected result has arrived, then lets
  // the pipeline drain requests that had no result.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // max_pwm is only written while no request is in flight.
  task automatic write_max_pwm(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [7:0] pwm;
    cmd_e       op;
    int         fault;
    int         target;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset value of max_pwm. A full drive with both
    // powers saturating in opposite directions.
    run_sequence(CMD_DRIVE, 16'h7FFF, 16'h8000, NO_FAULT, 1'b0);
    // Duties too small to move, so both nibbles stay clear; the control ack
    // is wrong, and commands arrive while the sequence is busy.
    run_sequence(CMD_DRIVE, 16'h0000, 16'h0010, 2, 1'b1);
    run_sequence(CMD_CATCH, random_power(), random_power(), NO_FAULT, 1'b0);
    // Bad handshake on a prepare-left.
    run_sequence(CMD_LEFT, random_power(), random_power(), 0, 1'b0);
    run_sequence(CMD_RIGHT, random_power(), random_power(), NO_FAULT, 1'b1);
    // A reply while idle and every unused command code.
    send_request(CMD_REPLY, random_power(), random_power(), REPLY_HELLO);
    for (int c = int'(CMD_REPLY) + 1; c < 8; c++) begin
      send_request(3'(c), random_power(), random_power(), 8'($urandom()));
    end
    wait_quiet();

    // Random part: each phase runs with its own max_pwm, extremes included.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       pwm = 8'd255;
        1:       pwm = 8'd0;
        2:       pwm = 8'd1;
        3:       pwm = 8'd128;
        4:       pwm = 8'd241;
        7:       pwm = 8'd2;
        default: pwm = 8'($urandom());
      endcase
      write_max_pwm(pwm);
      tx_idle_en <= (phase != BUSY_PHASE);
      rx_idle_en <= (phase != BUSY_PHASE);
      target = driven_items + ITEMS_PER_PHASE;
      while (driven_items < target) begin
        case ($urandom_range(19))
          0, 1: begin
            send_noise(1'b0);
          end
          2: begin
            wait_quiet();
          end
          default: begin
            op    = ($urandom_range(9) < 6) ? CMD_DRIVE : cmd_e'(3'($urandom_range(3, 1)));
            fault = ($urandom_range(9) < 7) ? NO_FAULT : int'($urandom_range(5));
            run_sequence(op, random_power(), random_power(), fault,
                         $urandom_range(4) == 0);
          end
        endcase
      end
      wait_quiet();
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("motor_command_spi_sequencer_unit verification clean");
    end else begin
      $display("motor_command_spi_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
